// ----- hdl/venc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// venc_pkg
// Shared types and constants of the variable-length integer encoder.
// ----------------------------------------------------------------------------
package venc_pkg;

  localparam int GroupBits       = 7;
  localparam int ValueBits       = 32;
  localparam int MaxGroups       = 5;
  localparam int ExtBits         = GroupBits * MaxGroups;
  localparam int LenBits         = 3;
  localparam int MaxLenWide      = 5;
  localparam int MaxLenNarrow    = 3;
  localparam int NarrowBits      = 16;
  localparam int QueueDepthDflt  = 2;

  // register indexes on the configuration port
  localparam logic RegSignedMode = 1'b0;
  localparam logic RegWideMode   = 1'b1;

  typedef struct packed {
    logic signed_mode;
    logic wide_mode;
  } venc_cfg_t;

  // one classified value: sign- or zero-extended to five groups, plus length
  typedef struct packed {
    logic [ExtBits-1:0] value;
    logic [LenBits-1:0] len;
  } venc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } venc_qstat_t;

endpackage : venc_pkg
`default_nettype wire

// ----- hdl/venc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// venc_front
// Accepts input values, extends them per mode and picks the encoded length.
// ----------------------------------------------------------------------------
module venc_front (
  input  var venc_pkg::venc_cfg_t   cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          value_bits,
  input  var venc_pkg::venc_qstat_t qstat,
  output logic                      push,
  output venc_pkg::venc_entry_t     push_entry
);
  import venc_pkg::*;

  logic [ExtBits-1:0] x;
  logic [MaxGroups-1:0] fit;
  logic [LenBits-1:0] len;
  logic [LenBits-1:0] max_len;

  always_comb begin
    if (cfg.wide_mode) begin
      x = cfg.signed_mode ? {{(ExtBits-ValueBits){value_bits[ValueBits-1]}}, value_bits}
                          : {{(ExtBits-ValueBits){1'b0}}, value_bits};
    end else begin
      x = cfg.signed_mode ?
          {{(ExtBits-NarrowBits){value_bits[NarrowBits-1]}}, value_bits[NarrowBits-1:0]} :
          {{(ExtBits-NarrowBits){1'b0}}, value_bits[NarrowBits-1:0]};
    end
  end

  // check each candidate length independently
  always_comb begin
    logic [ExtBits-1:0] mask_u;
    logic [ExtBits-1:0] mask_s;
    fit = '0;
    for (int k = 1; k < MaxGroups; k++) begin
      mask_u = {ExtBits{1'b1}} << (GroupBits * k);
      mask_s = {ExtBits{1'b1}} << (GroupBits * k - 1);
      if (cfg.signed_mode) begin
        fit[k] = ((x & mask_s) == '0) || ((x & mask_s) == mask_s);
      end else begin
        fit[k] = (x & mask_u) == '0;
      end
    end
  end

  // smallest fitting length, capped by the mode's maximum
  always_comb begin
    max_len = cfg.wide_mode ? LenBits'(MaxLenWide) : LenBits'(MaxLenNarrow);
    len = max_len;
    for (int k = MaxGroups - 1; k >= 1; k--) begin
      if (fit[k] && (LenBits'(k) < max_len)) begin
        len = LenBits'(k);
      end
    end
  end

  assign in_ready         = !qstat.full;
  assign push             = in_valid && in_ready;
  assign push_entry.value = x;
  assign push_entry.len   = len;

endmodule : venc_front
`default_nettype wire

// ----- hdl/venc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// venc_queue
// Small FIFO between the classifying front and the byte serializer.
// ----------------------------------------------------------------------------
module venc_queue #(
  parameter int Depth = venc_pkg::QueueDepthDflt
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  var venc_pkg::venc_entry_t  push_entry,
  input  wire logic                  pop,
  output venc_pkg::venc_entry_t      head,
  output venc_pkg::venc_qstat_t      qstat
);
  import venc_pkg::*;

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  venc_entry_t        mem [Depth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == CntBits'(Depth));
  assign qstat.empty = (count == '0);

endmodule : venc_queue
`default_nettype wire

// ----- hdl/venc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// venc_back
// Serializes queued values into encoded bytes, one per cycle unless the output stalls or the queue is empty.
// ----------------------------------------------------------------------------
module venc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  var venc_pkg::venc_entry_t  head,
  input  var venc_pkg::venc_qstat_t  qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       last_byte
);
  import venc_pkg::*;

  logic               busy;
  logic [ExtBits-1:0] value;
  logic [LenBits-1:0] rem;

  logic               load;
  logic [ExtBits-1:0] src_value;
  logic [LenBits-1:0] src_len;
  logic               src_last;

  assign load      = (!out_valid || out_ready) && (busy || !qstat.empty);
  assign pop       = load && !busy;
  assign src_value = busy ? value : head.value;
  assign src_len   = busy ? rem : head.len;
  assign src_last  = (src_len == LenBits'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        busy      <= !src_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= {!src_last, src_value[GroupBits-1:0]};
      last_byte <= src_last;
      value     <= src_value >> GroupBits;
      rem       <= src_len - 1'b1;
    end
  end

endmodule : venc_back
`default_nettype wire

// ----- hdl/varint_encoder_top.sv -----
`default_nettype none
// Path: an accepted value is first written into the queue, and its first byte
//   is then registered in the back end before it appears on the output.
// Throughput: one byte per cycle unless out_ready stalls or the queue is empty;
//   a value yields 1 to 5 bytes, its length, from the single back-end serializer.
// Reset: synchronous, active high; clears the queue and output valid, and
//   sets signed_mode to 0 and wide_mode to 1.
// ----------------------------------------------------------------------------
// varint_encoder_top
// LEB128-style encoder of 16- or 32-bit integers with an APB config port.
// ----------------------------------------------------------------------------
module varint_encoder_top #(
  parameter int QueueDepth = venc_pkg::QueueDepthDflt
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_byte
);
  import venc_pkg::*;

  venc_cfg_t   cfg;
  venc_qstat_t qstat;
  venc_entry_t push_entry;
  venc_entry_t head;
  logic        push;
  logic        pop;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signed_mode <= 1'b0;
      cfg.wide_mode   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegSignedMode: cfg.signed_mode <= pwdata[0];
        RegWideMode:   cfg.wide_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegSignedMode: prdata = {31'b0, cfg.signed_mode};
      RegWideMode:   prdata = {31'b0, cfg.wide_mode};
      default:       prdata = '0;
    endcase
  end

  venc_front u_front (
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value_bits (value_bits),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  venc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  venc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule : varint_encoder_top
`default_nettype wire
